@@ rtl/positional_list_insert_delete_assert.svh @@
// assertion macros used by the list rtl
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication
`define PLID_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/plid_pkg.sv @@
package plid_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int POS_W        = 5;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;
    localparam int WINDOW       = 1 << POS_W;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] value_out;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] index;
    } cmd_t;

endpackage

@@ rtl/plid_stream_if.sv @@
interface plid_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/plid_cell.sv @@
module plid_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  plid_pkg::cmd_t                     cmd,
    input  logic signed [plid_pkg::DATA_W-1:0] value,
    input  logic signed [plid_pkg::DATA_W-1:0] left_data,
    input  logic signed [plid_pkg::DATA_W-1:0] right_data,
    output logic signed [plid_pkg::DATA_W-1:0] data
);
    import plid_pkg::*;

    localparam bit              BEYOND = (IDX >= WINDOW);
    localparam logic [POS_W-1:0] IDX_S = POS_W'(IDX % WINDOW);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     at_idx;
    logic                     after_idx;

    assign at_idx    = !BEYOND && (cmd.index == IDX_S);
    assign after_idx = BEYOND || (IDX_S > cmd.index);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (at_idx)
                data_next = value;
            else if (after_idx)
                data_next = left_data;
        end
        else if (cmd.del)
        begin
            if (at_idx || after_idx)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/positional_list_insert_delete.sv @@
// the response is registered: response valid rises in the cycle after the request transfer
// throughput: one operation per cycle while the response side keeps up
// every insert or delete shifts the cells at and after the target position in the same cycle
// reset clears the entry count and the response valid; cell contents stay undefined
`include "positional_list_insert_delete_assert.svh"

module positional_list_insert_delete #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    plid_stream_if.sink          req,
    plid_stream_if.source        rsp
);
    import plid_pkg::*;

    localparam int UW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (UW > POS_W ? UW : POS_W) + 1;
    localparam int RD_N  = (CAPACITY < WINDOW) ? CAPACITY : WINDOW;

    logic [UW-1:0]            used_reg;
    logic [UW-1:0]            used_next;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_data_reg;
    rsp_t                     rsp_data_next;

    req_t                     r;
    logic                     fire;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         used_ext;
    logic                     pos_nz;
    logic                     ins_ok;
    logic                     rd_ok;
    logic                     del_ok;
    logic                     op_ok;
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] window    [WINDOW];

    assign r         = req.data;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    assign pos_ext  = CMP_W'(r.position);
    assign used_ext = CMP_W'(used_reg);
    assign pos_nz   = (r.position != '0);
    assign rd_ok    = pos_nz && (pos_ext <= used_ext);

    always_comb
    begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        op_ok  = 1'b0;
        case (r.mode)
            MODE_INSERT:
            begin
                ins_ok = pos_nz && (used_reg != UW'(CAPACITY))
                         && (pos_ext <= used_ext + CMP_W'(1));
                op_ok  = ins_ok;
            end
            MODE_READ:
            begin
                op_ok = rd_ok;
            end
            MODE_DELETE:
            begin
                del_ok = rd_ok;
                op_ok  = rd_ok;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign cmd.ins   = fire && ins_ok;
    assign cmd.del   = fire && del_ok;
    assign cmd.index = r.position - POS_W'(1);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            plid_cell #(
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .value      (r.value_in),
                .left_data  ((gi == 0) ? r.value_in : cell_data[(gi == 0) ? 0 : gi - 1]),
                .right_data ((gi == CAPACITY - 1) ? cell_data[gi]
                             : cell_data[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .data       (cell_data[gi])
            );
        end
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_window
            if (gi < RD_N)
            begin : g_live
                assign window[gi] = cell_data[gi];
            end
            else
            begin : g_none
                assign window[gi] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        used_next = used_reg;
        if (cmd.ins)
            used_next = used_reg + UW'(1);
        else if (cmd.del)
            used_next = used_reg - UW'(1);
    end

    always_comb
    begin
        rsp_data_next.ok        = op_ok;
        rsp_data_next.value_out = (rd_ok && (r.mode == MODE_READ || r.mode == MODE_DELETE))
                                  ? window[cmd.index] : '0;
        rsp_data_next.count     = COUNT_W'(used_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    `PLID_ASSERT_SAME(a_count_bound, 1'b1, used_reg <= UW'(CAPACITY), "entry count above capacity")
    `PLID_ASSERT_NEXT(a_ins_count, cmd.ins, used_reg == $past(used_reg) + UW'(1), "insert count slip")
    `PLID_ASSERT_NEXT(a_del_count, cmd.del, used_reg == $past(used_reg) - UW'(1), "delete count slip")
    `PLID_ASSERT_NEXT(a_fail_hold, fire && !op_ok, $stable(used_reg), "failed op changed count")
    `PLID_ASSERT_NEXT(a_rsp_after, fire, rsp_valid_reg, "no response after transfer")

endmodule
